// File: src/tile_map_rect_collision_unit_assert.svh
// assertion macros for the tile map rectangle collision unit
`ifndef TILE_MAP_RECT_COLLISION_UNIT_ASSERT_SVH
`define TILE_MAP_RECT_COLLISION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TMRC_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tmrc assertion failed");
`define TMRC_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tmrc assertion failed");
`else
`define TMRC_ASSERT_IMP(label, pre, post)
`define TMRC_ASSERT_NXT(label, pre, post)
`endif
`endif

// File: src/tmrc_pkg.sv
// shared constants, payload types and divider interface of the collision unit
`timescale 1ns / 1ps
package tmrc_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COLS_W   = $clog2(MAX_COLS + 1);
  localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
  localparam int MAP_W    = 7;
  localparam int DIM_W    = 9;
  localparam int COORD_W  = 16;
  localparam int SIZE_W   = 15;
  localparam int TILE_W   = 6;
  localparam int DIV_W    = 16;
  localparam int CNT_W    = $clog2(DIV_W + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  typedef enum logic [1:0] {
    CFG_MAP_COLS = 2'd0,
    CFG_MAP_ROWS = 2'd1,
    CFG_TILE_W   = 2'd2,
    CFG_TILE_H   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                      opcode;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic [SIZE_W-1:0]         rect_width;
    logic [SIZE_W-1:0]         rect_height;
    logic [TILE_W-1:0]         tile_col;
    logic [TILE_W-1:0]         tile_row;
    logic                      blocking_mark;
  } cmd_t;

  typedef struct packed {
    logic collides;
    logic outside_map;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: src/tile_map_rect_collision_unit.sv
// tile map rectangle collision unit: blocking bitmap, edge check and tile scan
//
//   channel  direction  handshake             payload
//   cmd      in         cmd_valid/cmd_ready   cmd (tmrc_pkg::cmd_t)
//   res      out        res_valid/res_ready   res (tmrc_pkg::res_t)
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// tile write: accept, then ST_FINISH, then the result register
// rectangle test: setup, edge check, four divider runs, a read and check per covered
//   tile row up to a hit, finish; outside or empty rectangles skip divider and scan
// after reset a clearing pass zeroes all MAX_ROWS bitmap rows, one row per cycle
// cmd is taken only between transactions; a held result stalls only the finish step
`timescale 1ns / 1ps
module tile_map_rect_collision_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  tmrc_pkg::cmd_t             cmd,
  output logic                       res_valid,
  input  logic                       res_ready,
  output tmrc_pkg::res_t             res,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  tmrc_pkg::cfg_index_t       cfg_index,
  input  logic [tmrc_pkg::DIM_W-1:0] cfg_data
);
  import tmrc_pkg::*;
  `include "tile_map_rect_collision_unit_assert.svh"

  localparam int PIX_W  = COLS_W + DIM_W;
  localparam int PIXH_W = ROWS_W + DIM_W;
  localparam int CMP_A  = (PIX_W > PIXH_W) ? PIX_W + 1 : PIXH_W + 1;
  localparam int CMP_W  = (CMP_A > COORD_W + 2) ? CMP_A : COORD_W + 2;

  typedef enum logic [8:0] {
    ST_CLEAR     = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_SETUP     = 9'b000000100,
    ST_CHECK     = 9'b000001000,
    ST_DIV_START = 9'b000010000,
    ST_DIV_WAIT  = 9'b000100000,
    ST_SCAN_RD   = 9'b001000000,
    ST_SCAN_CHK  = 9'b010000000,
    ST_FINISH    = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    DIV_X_FIRST = 2'd0,
    DIV_X_LAST  = 2'd1,
    DIV_Y_FIRST = 2'd2,
    DIV_Y_LAST  = 2'd3
  } div_sel_t;

  state_t             state;
  logic [ROW_W-1:0]   clear_row;
  logic [MAP_W-1:0]   map_cols;
  logic [MAP_W-1:0]   map_rows;
  logic [DIM_W-1:0]   tile_w;
  logic [DIM_W-1:0]   tile_h;
  cmd_t               req;
  logic [PIX_W-1:0]   pix_w;
  logic [PIXH_W-1:0]  pix_h;
  div_sel_t           div_idx;
  logic [COL_W-1:0]   c0;
  logic [COL_W-1:0]   c1;
  logic [ROW_W-1:0]   r0;
  logic [ROW_W-1:0]   r1;
  logic [ROW_W-1:0]   scan_row;
  logic               hit;
  logic               outside;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_row;

  logic [COLS_W-1:0]        cols_eff;
  logic [ROWS_W-1:0]        rows_eff;
  logic signed [CMP_W-1:0]  x_end;
  logic signed [CMP_W-1:0]  y_end;
  logic                     is_outside;
  logic                     is_empty;
  logic [MAX_COLS-1:0]      col_mask;
  logic                     tile_we;
  logic [ROW_W-1:0]         tile_wrow;
  logic [COL_W-1:0]         tile_wcol;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign cmd_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_cols <= MAP_W'(16);
      map_rows <= MAP_W'(16);
      tile_w   <= DIM_W'(16);
      tile_h   <= DIM_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAP_COLS: map_cols <= cfg_data[MAP_W-1:0];
        CFG_MAP_ROWS: map_rows <= cfg_data[MAP_W-1:0];
        CFG_TILE_W:   tile_w   <= cfg_data;
        CFG_TILE_H:   tile_h   <= cfg_data;
        default:      map_cols <= map_cols;
      endcase
    end
  end

  assign cols_eff = (32'(map_cols) > MAX_COLS) ? COLS_W'(MAX_COLS) : COLS_W'(map_cols);
  assign rows_eff = (32'(map_rows) > MAX_ROWS) ? ROWS_W'(MAX_ROWS) : ROWS_W'(map_rows);

  assign x_end = $signed({{(CMP_W-COORD_W){req.rect_left[COORD_W-1]}}, req.rect_left})
               + $signed({{(CMP_W-SIZE_W){1'b0}}, req.rect_width});
  assign y_end = $signed({{(CMP_W-COORD_W){req.rect_top[COORD_W-1]}}, req.rect_top})
               + $signed({{(CMP_W-SIZE_W){1'b0}}, req.rect_height});

  assign is_outside = req.rect_left[COORD_W-1] || req.rect_top[COORD_W-1]
                   || (x_end > $signed({{(CMP_W-PIX_W){1'b0}}, pix_w}))
                   || (y_end > $signed({{(CMP_W-PIXH_W){1'b0}}, pix_h}));
  assign is_empty   = (req.rect_width == '0) || (req.rect_height == '0);

  always_comb begin
    div_req.start   = (state == ST_DIV_START);
    div_req.divisor = div_idx[1] ? tile_h : tile_w;
    case (div_idx)
      DIV_X_FIRST: div_req.dividend = DIV_W'(unsigned'(req.rect_left));
      DIV_X_LAST:  div_req.dividend = DIV_W'(x_end - CMP_W'(1));
      DIV_Y_FIRST: div_req.dividend = DIV_W'(unsigned'(req.rect_top));
      DIV_Y_LAST:  div_req.dividend = DIV_W'(y_end - CMP_W'(1));
      default:     div_req.dividend = '0;
    endcase
  end

  tmrc_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (COL_W'(c) >= c0) && (COL_W'(c) <= c1);
    end
  end

  assign tile_we   = cmd_valid && cmd_ready && (cmd.opcode == OP_WRITE)
                  && (32'(cmd.tile_col) < MAX_COLS) && (32'(cmd.tile_row) < MAX_ROWS);
  assign tile_wrow = ROW_W'(cmd.tile_row);
  assign tile_wcol = COL_W'(cmd.tile_col);

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem[clear_row] <= '0;
    end else if (tile_we) begin
      mem[tile_wrow][tile_wcol] <= cmd.blocking_mark;
    end
    rd_row <= mem[scan_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_row <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != ST_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clear_row <= clear_row + 1'b1;
          if (clear_row == ROW_W'(MAX_ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            req <= cmd;
            if (cmd.opcode == OP_WRITE) begin
              hit     <= 1'b0;
              outside <= 1'b0;
              state   <= ST_FINISH;
            end else begin
              state <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          pix_w <= PIX_W'(cols_eff) * PIX_W'(tile_w);
          pix_h <= PIXH_W'(rows_eff) * PIXH_W'(tile_h);
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          hit     <= is_outside;
          outside <= is_outside;
          if (is_outside || is_empty) begin
            state <= ST_FINISH;
          end else begin
            div_idx <= DIV_X_FIRST;
            state   <= ST_DIV_START;
          end
        end
        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            case (div_idx)
              DIV_X_FIRST: c0 <= COL_W'(div_rsp.quotient);
              DIV_X_LAST:  c1 <= COL_W'(div_rsp.quotient);
              DIV_Y_FIRST: r0 <= ROW_W'(div_rsp.quotient);
              DIV_Y_LAST:  r1 <= ROW_W'(div_rsp.quotient);
              default:     c0 <= c0;
            endcase
            if (div_idx == DIV_Y_LAST) begin
              scan_row <= r0;
              state    <= ST_SCAN_RD;
            end else begin
              div_idx <= div_sel_t'(div_idx + 2'd1);
              state   <= ST_DIV_START;
            end
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (|(rd_row & col_mask)) begin
            hit   <= 1'b1;
            state <= ST_FINISH;
          end else if (scan_row == r1) begin
            state <= ST_FINISH;
          end else begin
            scan_row <= scan_row + 1'b1;
            state    <= ST_SCAN_RD;
          end
        end
        ST_FINISH: begin
          if (!res_valid || res_ready) begin
            res_valid       <= 1'b1;
            res.collides    <= hit;
            res.outside_map <= outside;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TMRC_ASSERT_NXT(a_write_to_finish, cmd_valid && cmd_ready && cmd.opcode == OP_WRITE, state == ST_FINISH)
  `TMRC_ASSERT_NXT(a_test_to_setup, cmd_valid && cmd_ready && cmd.opcode == OP_TEST, state == ST_SETUP)
  `TMRC_ASSERT_IMP(a_scan_row_range, state == ST_SCAN_CHK, scan_row >= r0 && scan_row <= r1)
  `TMRC_ASSERT_IMP(a_scan_bounds, state == ST_SCAN_RD || state == ST_SCAN_CHK, c0 <= c1 && r0 <= r1)
  `TMRC_ASSERT_IMP(a_outside_collides, res_valid, !res.outside_map || res.collides)

endmodule

// File: src/tmrc_divider.sv
// bit-serial restoring divider shared by the corner-to-tile conversions
`timescale 1ns / 1ps
module tmrc_divider (
  input  logic               clk,
  input  logic               rst,
  input  tmrc_pkg::div_req_t req,
  output tmrc_pkg::div_rsp_t rsp
);
  import tmrc_pkg::*;
  `include "tile_map_rect_collision_unit_assert.svh"

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dvd;
  logic [DIM_W-1:0] rem;
  logic [DIM_W:0]   trial;
  logic             fits;

  assign trial = {rem, dvd[DIV_W-1]};
  assign fits  = trial >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DIM_W'(trial - {1'b0, req.divisor});
      end else begin
        rem <= trial[DIM_W-1:0];
      end
      dvd <= {dvd[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dvd;

  `TMRC_ASSERT_IMP(a_start_when_idle, req.start, !busy)
  `TMRC_ASSERT_NXT(a_done_after_last, busy && cnt == CNT_W'(1), done && !busy)
  `TMRC_ASSERT_IMP(a_done_not_busy, done, !busy)
  `TMRC_ASSERT_IMP(a_busy_count, busy, cnt != '0)

endmodule
